@@ design/r5d_pkg.sv @@
// Shared package for the radix-5 real DFT block.
// Holds default widths, register map, direction codes, coefficient constants and helpers.
// No dependencies.
`timescale 1ns / 1ps

package r5d_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int NUM_POINTS         = 5;
    localparam int ADDR_WIDTH         = 3;
    localparam int DATA_WIDTH         = 32;

    // register index = paddr[2]
    localparam logic REG_DIRECTION = 1'b0;

    typedef enum logic {
        DIR_FORWARD  = 1'b0,
        DIR_BACKWARD = 1'b1
    } dir_t;

    typedef struct packed {
        logic load;
        dir_t dir;
    } stage_ctl_t;

    // coefficients, 32 fraction bits
    localparam logic [63:0] Q32_F_HALFSQRT5 = 64'd2400959709;
    localparam logic [63:0] Q32_F_SIN72     = 64'd4084756634;
    localparam logic [63:0] Q32_F_SIN36     = 64'd2524518436;
    localparam logic [63:0] Q32_B_SQRT5H    = 64'd4801919417;
    localparam logic [63:0] Q32_B_2SIN72    = 64'd8169513268;
    localparam logic [63:0] Q32_B_2SIN36    = 64'd5049036871;

    // round half up from 32 to frac fraction bits
    function automatic logic [63:0] coef_q(input logic [63:0] q32, input int frac);
        logic [63:0] half;
        half = 64'd1 << (31 - frac);
        return (q32 + half) >> (32 - frac);
    endfunction

endpackage

@@ design/r5d_pre.sv @@
// Stage 1 of the radix-5 real DFT: butterfly pre-adds and multiplier operand select.
// Depends on r5d_pkg.
`timescale 1ns / 1ps

module r5d_pre #(
    parameter int SAMPLE_WIDTH = r5d_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      aclk,
    input  r5d_pkg::stage_ctl_t       ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample [r5d_pkg::NUM_POINTS],
    output logic signed [SAMPLE_WIDTH+1:0] op_reg [r5d_pkg::NUM_POINTS],
    output logic signed [SAMPLE_WIDTH+1:0] lin0_reg,
    output logic signed [SAMPLE_WIDTH+1:0] lin1_reg
);

    localparam int OW = SAMPLE_WIDTH + 2;

    logic signed [OW-1:0] v [r5d_pkg::NUM_POINTS];
    logic signed [OW-1:0] s14, d14, s23, d23, sr, dr;
    logic signed [OW-1:0] op_next [r5d_pkg::NUM_POINTS];
    logic signed [OW-1:0] lin1_next;

    always_comb begin
        for (int i = 0; i < r5d_pkg::NUM_POINTS; i++) begin
            v[i] = OW'(sample[i]);
        end
        s14 = v[1] + v[4];
        d14 = v[1] - v[4];
        s23 = v[2] + v[3];
        d23 = v[2] - v[3];
        sr  = v[1] + v[3];
        dr  = v[1] - v[3];
        if (ctl.dir == r5d_pkg::DIR_FORWARD) begin
            op_next[0] = s14 - s23;
            op_next[1] = d23;
            op_next[2] = d14;
            op_next[3] = d23;
            op_next[4] = d14;
            lin1_next  = s14 + s23;
        end else begin
            op_next[0] = dr;
            op_next[1] = v[2];
            op_next[2] = v[4];
            op_next[3] = v[4];
            op_next[4] = v[2];
            lin1_next  = sr;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            op_reg   <= op_next;
            lin0_reg <= v[0];
            lin1_reg <= lin1_next;
        end
    end

endmodule

@@ design/r5d_mul.sv @@
// Stage 2 of the radix-5 real DFT: five shared constant multipliers with round half up,
// plus the exact scale-by-shift terms. Depends on r5d_pkg.
`timescale 1ns / 1ps

module r5d_mul #(
    parameter int SAMPLE_WIDTH   = r5d_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = r5d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  r5d_pkg::stage_ctl_t       ctl,
    input  logic signed [SAMPLE_WIDTH+1:0] op [r5d_pkg::NUM_POINTS],
    input  logic signed [SAMPLE_WIDTH+1:0] lin0,
    input  logic signed [SAMPLE_WIDTH+1:0] lin1,
    output logic signed [SAMPLE_WIDTH+2:0] rnd_reg [r5d_pkg::NUM_POINTS],
    output logic signed [SAMPLE_WIDTH+2:0] base_reg,
    output logic signed [SAMPLE_WIDTH+2:0] y0_reg
);

    localparam int OW = SAMPLE_WIDTH + 2;
    localparam int VW = SAMPLE_WIDTH + 3;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = OW + CW;

    localparam logic signed [CW-1:0] C_F_HSQ5 =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_F_HALFSQRT5, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] C_F_S72 =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_F_SIN72, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] C_F_S36 =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_F_SIN36, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] C_B_SQ5H =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_B_SQRT5H, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] C_B_2S72 =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_B_2SIN72, COEF_FRAC_BITS));
    localparam logic signed [CW-1:0] C_B_2S36 =
        CW'(r5d_pkg::coef_q(r5d_pkg::Q32_B_2SIN36, COEF_FRAC_BITS));
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [CW-1:0] coef [r5d_pkg::NUM_POINTS];
    logic signed [PW-1:0] prod [r5d_pkg::NUM_POINTS];
    logic signed [PW-1:0] acc  [r5d_pkg::NUM_POINTS];
    logic signed [PW-1:0] shf  [r5d_pkg::NUM_POINTS];
    logic signed [VW-1:0] rnd_next [r5d_pkg::NUM_POINTS];
    logic signed [VW-1:0] l0, l1, scaled, base_next, y0_next;

    always_comb begin
        if (ctl.dir == r5d_pkg::DIR_FORWARD) begin
            coef[0] = C_F_HSQ5;
            coef[1] = C_F_S36;
            coef[2] = C_F_S72;
            coef[3] = C_F_S72;
            coef[4] = C_F_S36;
        end else begin
            coef[0] = C_B_SQ5H;
            coef[1] = C_B_2S72;
            coef[2] = C_B_2S36;
            coef[3] = C_B_2S72;
            coef[4] = C_B_2S36;
        end
        for (int k = 0; k < r5d_pkg::NUM_POINTS; k++) begin
            prod[k]     = PW'(op[k]) * PW'(coef[k]);
            acc[k]      = prod[k] + HALF_LSB;
            shf[k]      = acc[k] >>> COEF_FRAC_BITS;
            rnd_next[k] = shf[k][VW-1:0];
        end
    end

    // x/4 and x/2 with round half up are exact shifts; x*2 is exact
    always_comb begin
        l0 = VW'(lin0);
        l1 = VW'(lin1);
        if (ctl.dir == r5d_pkg::DIR_FORWARD) begin
            scaled  = (l1 + VW'(2)) >>> 2;
            y0_next = l0 + l1;
        end else begin
            scaled  = (l1 + VW'(1)) >>> 1;
            y0_next = l0 + (l1 <<< 1);
        end
        base_next = l0 - scaled;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rnd_reg  <= rnd_next;
            base_reg <= base_next;
            y0_reg   <= y0_next;
        end
    end

endmodule

@@ design/r5d_post.sv @@
// Stages 3 and 4 of the radix-5 real DFT: rotation adds, then output butterflies.
// Depends on r5d_pkg.
`timescale 1ns / 1ps

module r5d_post #(
    parameter int SAMPLE_WIDTH = r5d_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      aclk,
    input  r5d_pkg::stage_ctl_t       ctl_add,
    input  r5d_pkg::stage_ctl_t       ctl_out,
    input  logic signed [SAMPLE_WIDTH+2:0] rnd [r5d_pkg::NUM_POINTS],
    input  logic signed [SAMPLE_WIDTH+2:0] base,
    input  logic signed [SAMPLE_WIDTH+2:0] y0,
    output logic signed [SAMPLE_WIDTH+2:0] value_reg [r5d_pkg::NUM_POINTS]
);

    localparam int VW = SAMPLE_WIDTH + 3;

    logic signed [VW-1:0] ea_reg, eb_reg, oa_reg, ob_reg, y0_s3_reg;
    logic signed [VW-1:0] value_next [r5d_pkg::NUM_POINTS];

    always_ff @(posedge aclk) begin
        if (ctl_add.load) begin
            ea_reg    <= base + rnd[0];
            eb_reg    <= base - rnd[0];
            oa_reg    <= rnd[1] + rnd[2];
            ob_reg    <= rnd[3] - rnd[4];
            y0_s3_reg <= y0;
        end
    end

    always_comb begin
        value_next[0] = y0_s3_reg;
        if (ctl_out.dir == r5d_pkg::DIR_FORWARD) begin
            value_next[1] = ea_reg;
            value_next[2] = -oa_reg;
            value_next[3] = eb_reg;
            value_next[4] = ob_reg;
        end else begin
            value_next[1] = ea_reg - oa_reg;
            value_next[2] = eb_reg + ob_reg;
            value_next[3] = eb_reg - ob_reg;
            value_next[4] = ea_reg + oa_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_out.load) begin
            value_reg <= value_next;
        end
    end

endmodule

@@ design/radix5_real_dft.sv @@
// Top level of the radix-5 real DFT: APB register, four-stage pipeline control.
// Depends on r5d_pkg, r5d_pre, r5d_mul, r5d_post.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_sample_0..4, s_batch_last
//  m_      | out       | m_valid/m_ready  | m_value_0..4, m_batch_end
//  apb     | in        | psel/penable     | paddr, pwdata, prdata (direction at 0x0)
//
// m_valid comes from the last of 4 register stages; one request per cycle unless m_ready stalls.
// Stages: pre-adds, constant multiplies, rotation adds, output butterflies.
// Each stage takes a new request when it is empty or its successor moves, so
// bubbles collapse and a stalled result holds without loss.
// aresetn is synchronous; it clears the valid bits and the direction register.
`timescale 1ns / 1ps

module radix5_real_dft #(
    parameter int SAMPLE_WIDTH   = r5d_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = r5d_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [r5d_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [r5d_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [r5d_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_0,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_1,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_2,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_3,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_4,
    input  logic                                s_batch_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_WIDTH+2:0]      m_value_0,
    output logic signed [SAMPLE_WIDTH+2:0]      m_value_1,
    output logic signed [SAMPLE_WIDTH+2:0]      m_value_2,
    output logic signed [SAMPLE_WIDTH+2:0]      m_value_3,
    output logic signed [SAMPLE_WIDTH+2:0]      m_value_4,
    output logic                                m_batch_end
);

    localparam int NS = 4;
    localparam int OW = SAMPLE_WIDTH + 2;
    localparam int VW = SAMPLE_WIDTH + 3;

    r5d_pkg::dir_t direction_reg;
    logic          stage_valid_reg [NS];
    logic          stage_last_reg  [NS];
    r5d_pkg::dir_t stage_dir_reg   [NS-1];
    logic          stage_rdy       [NS];
    logic          stage_load      [NS];
    logic          cfg_write;

    logic signed [SAMPLE_WIDTH-1:0] sample [r5d_pkg::NUM_POINTS];
    logic signed [OW-1:0] op [r5d_pkg::NUM_POINTS];
    logic signed [OW-1:0] lin0, lin1;
    logic signed [VW-1:0] rnd [r5d_pkg::NUM_POINTS];
    logic signed [VW-1:0] base, y0;
    logic signed [VW-1:0] value [r5d_pkg::NUM_POINTS];

    r5d_pkg::stage_ctl_t ctl_pre, ctl_mul, ctl_add, ctl_out;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= r5d_pkg::DIR_FORWARD;
        end else if (cfg_write && paddr[2] == r5d_pkg::REG_DIRECTION) begin
            direction_reg <= r5d_pkg::dir_t'(pwdata[0]);
        end
    end

    always_comb begin
        unique case (paddr[2])
            r5d_pkg::REG_DIRECTION: prdata = {{(r5d_pkg::DATA_WIDTH-1){1'b0}}, direction_reg};
            default:                prdata = '0;
        endcase
    end

    // pipeline control
    always_comb begin
        stage_rdy[NS-1] = !stage_valid_reg[NS-1] | m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !stage_valid_reg[k] | stage_rdy[k+1];
        end
        stage_load[0] = stage_rdy[0] & s_valid;
        for (int k = 1; k < NS; k++) begin
            stage_load[k] = stage_rdy[k] & stage_valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                stage_valid_reg[k] <= 1'b0;
            end
        end else begin
            if (stage_rdy[0]) begin
                stage_valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_rdy[k]) begin
                    stage_valid_reg[k] <= stage_valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            stage_last_reg[0] <= s_batch_last;
            stage_dir_reg[0]  <= direction_reg;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_load[k]) begin
                stage_last_reg[k] <= stage_last_reg[k-1];
            end
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (stage_load[k]) begin
                stage_dir_reg[k] <= stage_dir_reg[k-1];
            end
        end
    end

    assign s_ready     = stage_rdy[0];
    assign m_valid     = stage_valid_reg[NS-1];
    assign m_batch_end = stage_last_reg[NS-1];

    assign ctl_pre = '{load: stage_load[0], dir: direction_reg};
    assign ctl_mul = '{load: stage_load[1], dir: stage_dir_reg[0]};
    assign ctl_add = '{load: stage_load[2], dir: stage_dir_reg[1]};
    assign ctl_out = '{load: stage_load[3], dir: stage_dir_reg[2]};

    assign sample[0] = s_sample_0;
    assign sample[1] = s_sample_1;
    assign sample[2] = s_sample_2;
    assign sample[3] = s_sample_3;
    assign sample[4] = s_sample_4;

    r5d_pre #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pre (
        .aclk     (aclk),
        .ctl      (ctl_pre),
        .sample   (sample),
        .op_reg   (op),
        .lin0_reg (lin0),
        .lin1_reg (lin1)
    );

    r5d_mul #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .aclk     (aclk),
        .ctl      (ctl_mul),
        .op       (op),
        .lin0     (lin0),
        .lin1     (lin1),
        .rnd_reg  (rnd),
        .base_reg (base),
        .y0_reg   (y0)
    );

    r5d_post #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_post (
        .aclk      (aclk),
        .ctl_add   (ctl_add),
        .ctl_out   (ctl_out),
        .rnd       (rnd),
        .base      (base),
        .y0        (y0),
        .value_reg (value)
    );

    assign m_value_0 = value[0];
    assign m_value_1 = value[1];
    assign m_value_2 = value[2];
    assign m_value_3 = value[3];
    assign m_value_4 = value[4];

endmodule

@@ tb/radix5_real_dft_tb.sv @@
// Self-checking testbench for radix5_real_dft: directed vectors, then random requests in both
// directions with random idling on both channels, checked against an in-bench predictor.
// Depends on r5d_pkg and radix5_real_dft.
`timescale 1ns / 1ps

module radix5_real_dft_tb;

    localparam int SW = r5d_pkg::SAMPLE_WIDTH_DEF;
    localparam int CF = r5d_pkg::COEF_FRAC_BITS_DEF;
    localparam int VW = SW + 3;
    localparam int AW = r5d_pkg::ADDR_WIDTH;
    localparam int DW = r5d_pkg::DATA_WIDTH;

    localparam int SMAX = 32767;
    localparam int SMIN = -32768;

    localparam logic REG_SPARE = 1'b1;
    localparam logic [AW-1:0] DIR_ADDR   = {r5d_pkg::REG_DIRECTION, 2'b00};
    localparam logic [AW-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 115;

    // twiddles rounded from 32 to CF fraction bits
    localparam longint K_F_ROT = longint'((64'd2400959709 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_F_S72 = longint'((64'd4084756634 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_F_S36 = longint'((64'd2524518436 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_QUART = longint'((64'd1073741824 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_B_ROT = longint'((64'd4801919417 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_B_S72 = longint'((64'd8169513268 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_B_S36 = longint'((64'd5049036871 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_HALF  = longint'((64'd2147483648 + (64'd1 << (31 - CF))) >> (32 - CF));
    localparam longint K_TWO   = longint'((64'd8589934592 + (64'd1 << (31 - CF))) >> (32 - CF));

    typedef struct packed {
        logic [4:0][SW-1:0] smp;
        logic               last;
    } dft_req_t;

    typedef struct packed {
        logic [4:0][VW-1:0] val;
        logic               last;
    } dft_res_t;

    typedef struct packed {
        logic     known;
        dft_res_t res;
    } pinned_t;

    typedef struct {
        r5d_pkg::dir_t dir;
        dft_req_t      req;
        logic          known;
        dft_res_t      res;
    } vector_t;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [AW-1:0]         paddr        = '0;
    logic [DW-1:0]         pwdata       = '0;
    logic [DW-1:0]         prdata;
    logic                  pready;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic signed [SW-1:0]  s_sample_0   = '0;
    logic signed [SW-1:0]  s_sample_1   = '0;
    logic signed [SW-1:0]  s_sample_2   = '0;
    logic signed [SW-1:0]  s_sample_3   = '0;
    logic signed [SW-1:0]  s_sample_4   = '0;
    logic                  s_batch_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b1;
    logic signed [VW-1:0]  m_value_0;
    logic signed [VW-1:0]  m_value_1;
    logic signed [VW-1:0]  m_value_2;
    logic signed [VW-1:0]  m_value_3;
    logic signed [VW-1:0]  m_value_4;
    logic                  m_batch_end;

    r5d_pkg::dir_t dir_model = r5d_pkg::DIR_FORWARD;
    dft_res_t transform_out_q[$];
    pinned_t  pinned_q[$];
    vector_t  vectors[$];
    int       err_cnt      = 0;
    int       quiet_cycles = 0;
    bit       src_idle_en  = 1'b1;
    bit       sink_idle_en = 1'b1;
    bit       hold_off_req = 1'b0;

    radix5_real_dft i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_0   (s_sample_0),
        .s_sample_1   (s_sample_1),
        .s_sample_2   (s_sample_2),
        .s_sample_3   (s_sample_3),
        .s_sample_4   (s_sample_4),
        .s_batch_last (s_batch_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_0    (m_value_0),
        .m_value_1    (m_value_1),
        .m_value_2    (m_value_2),
        .m_value_3    (m_value_3),
        .m_value_4    (m_value_4),
        .m_batch_end  (m_batch_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // constant multiply, rounded half up
    function automatic longint round_mul(input longint v, input longint k);
        longint p;
        p = v * k + (longint'(1) << (CF - 1));
        return p >>> CF;
    endfunction

    function automatic dft_res_t radix5_transform(input r5d_pkg::dir_t dir, input dft_req_t r);
        longint   x[5];
        longint   y[5];
        longint   s14, d14, s23, d23, sum, sr, dr, base, rot, ea, eb, oa, ob;
        dft_res_t o;
        int       i;
        for (i = 0; i < 5; i++)
            x[i] = longint'($signed(r.smp[i]));
        if (dir == r5d_pkg::DIR_FORWARD) begin
            s14  = x[1] + x[4];
            d14  = x[1] - x[4];
            s23  = x[2] + x[3];
            d23  = x[2] - x[3];
            sum  = s14 + s23;
            base = x[0] - round_mul(sum, K_QUART);
            rot  = round_mul(s14 - s23, K_F_ROT);
            y[0] = x[0] + sum;
            y[1] = base + rot;
            y[2] = -round_mul(d23, K_F_S36) - round_mul(d14, K_F_S72);
            y[3] = base - rot;
            y[4] = round_mul(d23, K_F_S72) - round_mul(d14, K_F_S36);
        end else begin
            sr   = x[1] + x[3];
            dr   = x[1] - x[3];
            base = x[0] - round_mul(sr, K_HALF);
            rot  = round_mul(dr, K_B_ROT);
            ea   = base + rot;
            eb   = base - rot;
            oa   = round_mul(x[2], K_B_S72) + round_mul(x[4], K_B_S36);
            ob   = round_mul(x[4], K_B_S72) - round_mul(x[2], K_B_S36);
            y[0] = x[0] + round_mul(sr, K_TWO);
            y[1] = ea - oa;
            y[2] = eb + ob;
            y[3] = eb - ob;
            y[4] = ea + oa;
        end
        for (i = 0; i < 5; i++)
            o.val[i] = VW'(y[i]);
        o.last = r.last;
        return o;
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return SW'($urandom_range(0, 8) - 4);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic dft_req_t random_req();
        dft_req_t r;
        int       i;
        int       pick;
        pick = $urandom_range(0, 7);
        for (i = 0; i < 5; i++) begin
            if (pick == 0)
                r.smp[i] = $urandom_range(0, 1) ? SW'(SMAX) : SW'(SMIN);
            else
                r.smp[i] = rand_sample();
        end
        r.last = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic add_row(input r5d_pkg::dir_t d, input int a0, input int a1, input int a2,
                           input int a3, input int a4, input bit lst, input bit known,
                           input int e0, input int e1, input int e2, input int e3,
                           input int e4);
        vector_t v;
        v.dir    = d;
        v.req    = {SW'(a4), SW'(a3), SW'(a2), SW'(a1), SW'(a0), lst};
        v.known  = known;
        v.res    = {VW'(e4), VW'(e3), VW'(e2), VW'(e1), VW'(e0), lst};
        vectors.push_back(v);
    endtask

    task automatic apb_access(input logic wr, input logic [AW-1:0] addr,
                              input logic [DW-1:0] wdata,
                              output logic [DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr && addr[AW-1:2] == r5d_pkg::REG_DIRECTION)
            dir_model = r5d_pkg::dir_t'(wdata[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_direction();
        logic [DW-1:0] rd;
        apb_access(1'b0, DIR_ADDR, '0, rd);
        if (rd[0] !== dir_model)
            report_mismatch("direction readback", rd[0], dir_model);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (transform_out_q.size() != 0)
            @(posedge aclk);
    endtask

    // write direction with junk in the upper bits; optionally poke the unmapped slot
    task automatic set_direction(input r5d_pkg::dir_t d, input bit poke_spare);
        logic [DW-1:0] rd;
        drain();
        apb_access(1'b1, DIR_ADDR, {31'($urandom()), d}, rd);
        if (poke_spare)
            apb_access(1'b1, SPARE_ADDR, {{(DW-1){1'b1}}, ~d}, rd);
        check_direction();
    endtask

    task automatic send_req(input dft_req_t r, input logic known, input dft_res_t res);
        pinned_t pin;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        pin.known = known;
        pin.res   = res;
        pinned_q.push_back(pin);
        s_valid      <= 1'b1;
        s_sample_0   <= r.smp[0];
        s_sample_1   <= r.smp[1];
        s_sample_2   <= r.smp[2];
        s_sample_3   <= r.smp[3];
        s_sample_4   <= r.smp[4];
        s_batch_last <= r.last;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin : request_capture
        pinned_t  pin;
        dft_req_t req;
        if (aresetn && s_valid && s_ready) begin
            req = {s_sample_4, s_sample_3, s_sample_2, s_sample_1, s_sample_0, s_batch_last};
            pin = pinned_q.pop_front();
            transform_out_q.push_back(pin.known ? pin.res : radix5_transform(dir_model, req));
        end
    end

    always @(posedge aclk) begin : result_check
        dft_res_t got;
        dft_res_t want;
        int       i;
        if (aresetn && m_valid && m_ready) begin
            got = {m_value_4, m_value_3, m_value_2, m_value_1, m_value_0, m_batch_end};
            if (transform_out_q.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = transform_out_q.pop_front();
                for (i = 0; i < 5; i++)
                    if (got.val[i] !== want.val[i])
                        report_mismatch($sformatf("value_%0d", i),
                                        longint'($signed(got.val[i])),
                                        longint'($signed(want.val[i])));
                if (got.last !== want.last)
                    report_mismatch("batch_end", got.last, want.last);
            end
        end
    end

    // sink stalls; a requested hold-off backs the pipeline up into s_ready
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (40) @(posedge aclk);
                m_ready <= 1'b1;
                hold_off_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        dft_res_t none;
        int       ph;
        int       n;
        none = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_direction();

        // forward: impulses, flat inputs, extremes, rounding edges
        add_row(r5d_pkg::DIR_FORWARD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMAX, 0, 0, 0, 0, 1, 1, SMAX, SMAX, 0, SMAX, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMIN, 0, 0, 0, 0, 0, 1, SMIN, SMIN, 0, SMIN, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMAX, SMAX, SMAX, SMAX, SMAX, 1, 1, 5 * SMAX, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 1, 5 * SMIN, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, -1, -1, -1, -1, -1, 1, 1, -5, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, 0, SMAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, 0, SMIN, 0, 0, SMAX, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, 0, 0, SMIN, SMAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMAX, SMIN, SMAX, SMIN, SMAX, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, SMIN, SMAX, SMIN, SMAX, SMIN, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, 0, 1, 0, 0, -1, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_FORWARD, 0, SMAX, SMIN, SMIN, SMAX, 0, 0, 0, 0, 0, 0, 0);
        // backward: dc only, extremes of each pair
        add_row(r5d_pkg::DIR_BACKWARD, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, SMAX, 0, 0, 0, 0, 0, 1, SMAX, SMAX, SMAX, SMAX, SMAX);
        add_row(r5d_pkg::DIR_BACKWARD, SMIN, 0, 0, 0, 0, 1, 1, SMIN, SMIN, SMIN, SMIN, SMIN);
        add_row(r5d_pkg::DIR_BACKWARD, 0, SMAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, 0, SMIN, 0, SMAX, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, 0, 0, SMAX, 0, SMAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, 0, 0, SMIN, 0, SMIN, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, 0, 0, SMIN, 0, SMAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, SMAX, SMAX, SMAX, SMAX, SMAX, 1, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0, 0, 0, 0);
        add_row(r5d_pkg::DIR_BACKWARD, 1, -1, 1, -1, 1, 1, 0, 0, 0, 0, 0, 0);

        foreach (vectors[k]) begin
            if (vectors[k].dir != dir_model)
                set_direction(vectors[k].dir, 1'b0);
            send_req(vectors[k].req, vectors[k].known, vectors[k].res);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            set_direction(ph % 2 ? r5d_pkg::DIR_BACKWARD : r5d_pkg::DIR_FORWARD, ph == 4);
            src_idle_en  = (ph < PHASES - 1);
            sink_idle_en = (ph < PHASES - 1);
            for (n = 0; n < PHASE_REQS; n++) begin
                if (ph == 1 && n == 20)
                    hold_off_req = 1'b1;
                send_req(random_req(), 1'b0, none);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (transform_out_q.size() != 0)
            report_mismatch("results never delivered", transform_out_q.size(), 0);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
